[design/tksl_pkg.sv]
package tksl_pkg;

   // Field widths
   localparam int SCORE_BITS = 32;
   localparam int TAG_BITS   = 16;
   localparam int OPC_BITS   = 2;
   localparam int IDX_BITS   = 4;
   localparam int CNT_BITS   = 5;

   localparam int DEPTH_DEFAULT = 16;
   localparam logic [CNT_BITS-1:0] MAX_ENTRIES_RESET = 5'd16;

   // Stream word widths, padded to whole bytes
   localparam int REQ_FIELD_BITS = SCORE_BITS + TAG_BITS + IDX_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + IDX_BITS + CNT_BITS + 1 + SCORE_BITS + TAG_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [OPC_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [SCORE_BITS-1:0] score;
      logic [TAG_BITS-1:0]   tag;
      logic [IDX_BITS-1:0]   read_index;
   } cmd_type;

   typedef struct packed {
      logic                  kept;
      logic [IDX_BITS-1:0]   rank;
      logic [CNT_BITS-1:0]   entry_count;
      logic                  index_valid;
      logic [SCORE_BITS-1:0] entry_score;
      logic [TAG_BITS-1:0]   entry_tag;
   } result_type;

endpackage

[design/tksl_ram.sv]
module tksl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tksl_engine.sv]
module tksl_engine #(
   parameter int DEPTH = tksl_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  tksl_pkg::cmd_type             cmd,
   input  logic [tksl_pkg::CNT_BITS-1:0] max_entries,
   output logic                          res_valid,
   input  logic                          res_take,
   output tksl_pkg::result_type          res
);
   import tksl_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > CNT_BITS) ? CW : CNT_BITS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RDWAIT, S_DONE} state_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [TAG_BITS-1:0]   tag;
   } entry_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          pd_valid_ff, pd_valid_in;
   logic [AW-1:0] pd_idx_ff, pd_idx_in;
   logic          ins_ff, ins_in;
   logic [AW-1:0] rank_ff, rank_in;
   entry_type     held_ff, held_in;
   result_type    res_ff, res_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   logic [XW-1:0] lim_x;
   logic [XW:0]   c1_x;
   logic [CW-1:0] n_new;
   logic          old_wins;
   logic          pd_last;
   logic          rd_hit;

   tksl_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // New list length: one more than now, capped by the limit.
   assign lim_x = (XW'(max_entries) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(max_entries);
   assign c1_x  = (XW + 1)'(fill_ff) + (XW + 1)'(1);
   assign n_new = (c1_x < (XW + 1)'(lim_x)) ? CW'(c1_x) : CW'(lim_x);

   // A stored entry with an equal or greater score stays ahead of the new pair.
   assign old_wins = (CW'(pd_idx_ff) < fill_ff) && (rd_data.score >= cmd_ff.score);
   assign pd_last  = (CW'(pd_idx_ff) == (n_ff - CW'(1)));
   assign rd_hit   = (XW'(cmd_ff.read_index) < XW'(fill_ff));

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      fill_in     = fill_ff;
      n_in        = n_ff;
      rd_idx_in   = rd_idx_ff;
      pd_valid_in = pd_valid_ff;
      pd_idx_in   = pd_idx_ff;
      ins_in      = ins_ff;
      rank_in     = rank_ff;
      held_in     = held_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = pd_idx_ff;
      wr_data     = held_ff;
      rd_addr     = rd_idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = AW'(cmd.read_index);
            if (cmd_valid) begin
               cmd_in = cmd;
               res_in = '0;
               unique case (cmd.opcode)
                  OP_INSERT: begin
                     n_in        = n_new;
                     rd_idx_in   = '0;
                     pd_valid_in = 1'b0;
                     ins_in      = 1'b0;
                     rank_in     = '0;
                     if (n_new == '0) begin
                        fill_in  = '0;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_READ: begin
                     state_in = S_RDWAIT;
                  end
                  OP_CLEAR: begin
                     fill_in  = '0;
                     state_in = S_DONE;
                  end
                  OP_NOP: begin
                     res_in.entry_count = CNT_BITS'(fill_ff);
                     state_in           = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Reads run one entry ahead of the compare and write-back stage.
            if (rd_idx_ff < n_ff) begin
               rd_idx_in   = rd_idx_ff + CW'(1);
               pd_valid_in = 1'b1;
               pd_idx_in   = rd_idx_ff[AW-1:0];
            end else begin
               pd_valid_in = 1'b0;
            end
            if (pd_valid_ff) begin
               // Once the new pair is placed, each entry moves down by one.
               if (ins_ff) begin
                  wr_en   = 1'b1;
                  wr_data = held_ff;
                  held_in = rd_data;
               end else if (!old_wins) begin
                  wr_en   = 1'b1;
                  wr_data = '{score: cmd_ff.score, tag: cmd_ff.tag};
                  held_in = rd_data;
                  ins_in  = 1'b1;
                  rank_in = pd_idx_ff;
               end
               if (pd_last) begin
                  fill_in            = n_ff;
                  res_in.kept        = ins_in;
                  res_in.rank        = ins_in ? IDX_BITS'(rank_in) : '0;
                  res_in.entry_count = CNT_BITS'(n_ff);
                  pd_valid_in        = 1'b0;
                  state_in           = S_DONE;
               end
            end
         end

         S_RDWAIT: begin
            res_in.entry_count = CNT_BITS'(fill_ff);
            res_in.index_valid = rd_hit;
            if (rd_hit) begin
               res_in.entry_score = rd_data.score;
               res_in.entry_tag   = rd_data.tag;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         pd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         pd_valid_ff <= pd_valid_in;
      end
      cmd_ff    <= cmd_in;
      n_ff      <= n_in;
      rd_idx_ff <= rd_idx_in;
      pd_idx_ff <= pd_idx_in;
      ins_ff    <= ins_in;
      rank_ff   <= rank_in;
      held_ff   <= held_in;
      res_ff    <= res_in;
   end

   assign cmd_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

[design/top_k_sorted_score_list_top.sv]
// Channel | Ports           | Word contents
// req     | req_t*          | tdata: new_score, new_tag, read_index; tuser: opcode
// rsp     | rsp_t*          | tdata: kept, rank, entry_count, index_valid, entry_score, entry_tag
// csr     | csr_wr_*        | max_entries, written whenever csr_wr_en is high
//
// An insert makes one memory read per entry up to n, the new list length, with the
// compare and write-back one entry behind the reads. One word is worked on at a time;
// req_tready is high while the sequencer is idle, even when a result still waits in the
// output register. Reset empties the list and sets the limit to sixteen; memory is kept.
module top_k_sorted_score_list_top #(
   parameter int DEPTH = tksl_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // new_score, new_tag, read_index (zero padded)
   input  logic [tksl_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // opcode
   input  logic [tksl_pkg::OPC_BITS-1:0]       req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // kept, rank, entry_count, index_valid, entry_score, entry_tag (zero padded)
   output logic [tksl_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [tksl_pkg::CNT_BITS-1:0]       csr_wr_data
);
   import tksl_pkg::*;

   logic [CNT_BITS-1:0] max_entries_ff, max_entries_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_res_ff, rsp_res_in;

   cmd_type    cmd;
   logic       eng_ready;
   logic       eng_valid;
   logic       eng_take;
   result_type eng_res;

   assign cmd.opcode     = opcode_type'(req_tuser);
   assign cmd.score      = req_tdata[SCORE_BITS-1:0];
   assign cmd.tag        = req_tdata[SCORE_BITS +: TAG_BITS];
   assign cmd.read_index = req_tdata[SCORE_BITS + TAG_BITS +: IDX_BITS];

   tksl_engine #(
      .DEPTH(DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_tvalid),
      .cmd_ready  (eng_ready),
      .cmd        (cmd),
      .max_entries(max_entries_ff),
      .res_valid  (eng_valid),
      .res_take   (eng_take),
      .res        (eng_res)
   );

   assign req_tready = eng_ready;

   // The output register takes a new word when empty or being drained.
   assign eng_take = eng_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      max_entries_in = csr_wr_en ? csr_wr_data : max_entries_ff;
      rsp_res_in     = eng_take ? eng_res : rsp_res_ff;
      if (eng_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_entries_ff <= max_entries_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      (RSP_TDATA_BITS - RSP_FIELD_BITS)'(0),
      rsp_res_ff.entry_tag,
      rsp_res_ff.entry_score,
      rsp_res_ff.index_valid,
      rsp_res_ff.entry_count,
      rsp_res_ff.rank,
      rsp_res_ff.kept
   };

endmodule

[tb/tb_top.sv]
module tb_top;
   import tksl_pkg::*;

   localparam int RANK_LO   = 1;
   localparam int COUNT_LO  = RANK_LO + IDX_BITS;
   localparam int VALID_BIT = COUNT_LO + CNT_BITS;
   localparam int SCORE_LO  = VALID_BIT + 1;
   localparam int TAG_LO    = SCORE_LO + SCORE_BITS;
   localparam int NUM_PHASES = 10;
   localparam int PHASE_ITEMS = 165;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [OPC_BITS-1:0]       req_tuser = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_wr_en = 1'b0;
   logic [CNT_BITS-1:0]       csr_wr_data = '0;

   top_k_sorted_score_list_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   cmd_type    pending_cmds[$];
   result_type expected_results[$];
   cmd_type    offered_cmd;
   logic       req_taken = 1'b0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       long_hold_req = 1'b0;
   logic       long_hold_done = 1'b0;
   int         hold_left = 0;
   int         mismatch_count = 0;

   logic [CNT_BITS-1:0] phase_limit[NUM_PHASES] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd16,
                                                    5'd7, 5'd17, 5'd2, 5'd16, 5'd12};

   // Shadow copy of the sorted list and its limit.
   logic [SCORE_BITS-1:0] list_score[DEPTH_DEFAULT];
   logic [TAG_BITS-1:0]   list_tag[DEPTH_DEFAULT];
   int                    list_count = 0;
   logic [CNT_BITS-1:0]   limit_cfg = MAX_ENTRIES_RESET;

   function automatic result_type apply_list_op(cmd_type c);
      result_type r;
      int lim;
      int pos;
      int len;
      int i;
      r = '0;
      case (c.opcode)
         OP_INSERT: begin
            lim = (limit_cfg > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(limit_cfg);
            pos = 0;
            // A new pair goes behind every stored pair of equal or greater score.
            while (pos < list_count && list_score[pos] >= c.score) pos++;
            len = (list_count + 1 < lim) ? list_count + 1 : lim;
            if (pos < len) begin
               for (i = len - 1; i > pos; i--) begin
                  list_score[i] = list_score[i-1];
                  list_tag[i]   = list_tag[i-1];
               end
               list_score[pos] = c.score;
               list_tag[pos]   = c.tag;
               r.kept = 1'b1;
               r.rank = pos[IDX_BITS-1:0];
            end
            list_count = len;
         end
         OP_READ: begin
            if (int'(c.read_index) < list_count) begin
               r.index_valid = 1'b1;
               r.entry_score = list_score[c.read_index];
               r.entry_tag   = list_tag[c.read_index];
            end
         end
         OP_CLEAR: list_count = 0;
         default: ;
      endcase
      r.entry_count = list_count[CNT_BITS-1:0];
      return r;
   endfunction

   task automatic queue_cmd(opcode_type op, logic [SCORE_BITS-1:0] score,
                            logic [TAG_BITS-1:0] tag, logic [IDX_BITS-1:0] idx);
      cmd_type c;
      c.opcode = op;
      c.score = score;
      c.tag = tag;
      c.read_index = idx;
      pending_cmds = {pending_cmds, c};
   endtask

   function automatic cmd_type random_cmd();
      cmd_type c;
      int roll;
      roll = $urandom_range(0, 99);
      // Clears are kept rare so that the list fills up and starts dropping pairs.
      if (roll < 52) c.opcode = OP_INSERT;
      else if (roll < 90) c.opcode = OP_READ;
      else if (roll < 97) c.opcode = OP_NOP;
      else c.opcode = OP_CLEAR;
      case ($urandom_range(0, 3))
         0: c.score = $urandom_range(0, 7);
         1: c.score = 32'hFFFF_FFF8 | $urandom_range(0, 7);
         default: c.score = $urandom;
      endcase
      c.tag = TAG_BITS'($urandom);
      c.read_index = IDX_BITS'($urandom_range(0, 15));
      return c;
   endfunction

   task automatic flag_mismatch(string why, result_type want, result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected kept=%0d rank=%0d count=%0d valid=%0d score=%h tag=%h",
                  why, want.kept, want.rank, want.entry_count, want.index_valid,
                  want.entry_score, want.entry_tag);
         $display("   got kept=%0d rank=%0d count=%0d valid=%0d score=%h tag=%h",
                  got.kept, got.rank, got.entry_count, got.index_valid,
                  got.entry_score, got.entry_tag);
      end
   endtask

   // Request driver: a word stays on the bus until it is taken.
   always @(negedge clock) begin
      logic [REQ_TDATA_BITS-1:0] word;
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         offer = pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
         if (offer) begin
            offered_cmd = pending_cmds.pop_front();
            word = '0;
            word[SCORE_BITS-1:0] = offered_cmd.score;
            word[SCORE_BITS +: TAG_BITS] = offered_cmd.tag;
            word[SCORE_BITS + TAG_BITS +: IDX_BITS] = offered_cmd.read_index;
            req_tdata <= word;
            req_tuser <= offered_cmd.opcode;
         end
         req_tvalid <= offer;
      end
   end

   // Response sink with random stalls and one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_req && !long_hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(0, 99) >= recv_stall_pct;
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.kept        = rsp_tdata[0];
            got.rank        = rsp_tdata[RANK_LO +: IDX_BITS];
            got.entry_count = rsp_tdata[COUNT_LO +: CNT_BITS];
            got.index_valid = rsp_tdata[VALID_BIT];
            got.entry_score = rsp_tdata[SCORE_LO +: SCORE_BITS];
            got.entry_tag   = rsp_tdata[TAG_LO +: TAG_BITS];
            if (expected_results.size() == 0) begin
               flag_mismatch("unexpected result word", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) flag_mismatch("result mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready)
            expected_results = {expected_results, apply_list_op(offered_cmd)};
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty reads, extreme scores, ties at both ends, read past the count.
      queue_cmd(OP_READ, '0, '0, 4'd0);
      queue_cmd(OP_NOP, '1, '1, 4'd15);
      queue_cmd(OP_INSERT, 32'h0, 16'h0, 4'd0);
      queue_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 4'd0);
      queue_cmd(OP_INSERT, 32'd5, 16'd1, 4'd0);
      queue_cmd(OP_INSERT, 32'd5, 16'd2, 4'd0);
      queue_cmd(OP_INSERT, 32'd5, 16'd3, 4'd0);
      queue_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 4'd0);
      queue_cmd(OP_INSERT, 32'h0, 16'h5555, 4'd0);
      for (int i = 0; i < 8; i++) queue_cmd(OP_READ, '0, '0, i[IDX_BITS-1:0]);
      queue_cmd(OP_READ, '0, '0, 4'd15);
      queue_cmd(OP_CLEAR, '0, '0, 4'd0);
      queue_cmd(OP_READ, '0, '0, 4'd0);
      queue_cmd(OP_INSERT, 32'd1, 16'd7, 4'd0);
      queue_cmd(OP_READ, '0, '0, 4'd0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // Hold back new words until the block has answered everything.
         while (pending_cmds.size() != 0 || req_tvalid || expected_results.size() != 0)
            @(posedge clock);
         repeat (25) @(posedge clock);
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_wr_data <= phase_limit[p];
         limit_cfg = phase_limit[p];
         @(negedge clock);
         csr_wr_en <= 1'b0;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         // A few reads first, so a lowered limit is seen before the next insert trims.
         for (int i = 0; i < 3; i++)
            queue_cmd(OP_READ, '0, '0, IDX_BITS'($urandom_range(0, 15)));
         for (int i = 0; i < PHASE_ITEMS; i++) pending_cmds = {pending_cmds, random_cmd()};
         if (p == 4) long_hold_req = 1'b1;
      end

      while (pending_cmds.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** top_k_sorted_score_list_top: PASSED **");
      end else begin
         $display("** top_k_sorted_score_list_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("** top_k_sorted_score_list_top: FAILED **");
      $finish;
   end

endmodule
